// ===== sv/ibsc_pkg.sv =====
// Package for the idle bouncing sprite controller.
// Holds operation and register index codes, reset values and the motion word type.
// No dependencies.
package ibsc_pkg;

  // Operation codes carried on the op input.
  localparam logic OP_KICK = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPRITE_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPRITE_HEIGHT  = 3'd5;

  // Field widths.
  localparam int TIME_BITS     = 32;
  localparam int INTERVAL_BITS = 16;
  localparam int DIM_BITS      = 12;

  // Register reset values.
  localparam logic [TIME_BITS-1:0]     IDLE_TIMEOUT_RST   = 32'd60000;
  localparam logic [INTERVAL_BITS-1:0] FRAME_INTERVAL_RST = 16'd20;
  localparam logic [DIM_BITS-1:0]      SCREEN_WIDTH_RST   = 12'd640;
  localparam logic [DIM_BITS-1:0]      SCREEN_HEIGHT_RST  = 12'd480;
  localparam logic [DIM_BITS-1:0]      SPRITE_WIDTH_RST   = 12'd360;
  localparam logic [DIM_BITS-1:0]      SPRITE_HEIGHT_RST  = 12'd40;

  // Sprite positions at reset and on activation, and the speed per frame.
  localparam int SPRITE_RESET_POS = 80;
  localparam int SPRITE_START_POS = 100;
  localparam int VEL_MAG          = 2;

  // Direction and colour of the sprite. The speed is always two pixels, so
  // each axis keeps only its sign (1 means moving towards zero).
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic accent;
  } motion_t;

endpackage

// ===== sv/ibsc_move.sv =====
// Sprite step and edge bounce for the idle bouncing sprite controller.
// Purely combinational; depends on ibsc_pkg for the motion word and widths.
module ibsc_move
  import ibsc_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  motion_t                      mot_i,
  input  logic        [DIM_BITS-1:0]   scr_w_i,
  input  logic        [DIM_BITS-1:0]   scr_h_i,
  input  logic        [DIM_BITS-1:0]   spr_w_i,
  input  logic        [DIM_BITS-1:0]   spr_h_i,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o,
  output motion_t                      mot_o
);

  // Working width holds a coordinate plus a sprite size without overflow.
  localparam int EW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
  localparam logic signed [EW-1:0] STEP_POS = EW'(VEL_MAG);
  localparam logic signed [EW-1:0] STEP_NEG = -STEP_POS;

  logic signed [EW-1:0] sw_e, sh_e, lw_e, lh_e;
  logic signed [EW-1:0] x_w, y_w;
  motion_t              mot_w;

  assign sw_e = EW'(scr_w_i);
  assign sh_e = EW'(scr_h_i);
  assign lw_e = EW'(spr_w_i);
  assign lh_e = EW'(spr_h_i);

  // Step, then check the left, top, right and bottom edges in that order.
  always_comb begin
    mot_w = mot_i;
    x_w   = EW'(x_i) + (mot_i.neg_x ? STEP_NEG : STEP_POS);
    y_w   = EW'(y_i) + (mot_i.neg_y ? STEP_NEG : STEP_POS);

    if (x_w[EW-1]) begin
      x_w          = '0;
      mot_w.neg_x  = ~mot_w.neg_x;
      mot_w.accent = 1'b1;
    end
    if (y_w[EW-1]) begin
      y_w          = '0;
      mot_w.neg_y  = ~mot_w.neg_y;
      mot_w.accent = 1'b1;
    end
    if ((x_w + lw_e) > sw_e) begin
      x_w          = sw_e - lw_e;
      mot_w.neg_x  = ~mot_w.neg_x;
      mot_w.accent = 1'b0;
    end
    if ((y_w + lh_e) > sh_e) begin
      y_w          = sh_e - lh_e;
      mot_w.neg_y  = ~mot_w.neg_y;
      mot_w.accent = 1'b0;
    end
  end

  // Stored coordinates wrap to the coordinate width.
  assign x_o   = x_w[COORD_BITS-1:0];
  assign y_o   = y_w[COORD_BITS-1:0];
  assign mot_o = mot_w;

endmodule

// ===== sv/idle_bouncing_sprite_controller_unit.sv =====
// Idle bouncing sprite controller: idle detection, frame throttling and sprite bounce.
// A word is accepted into the input register and then moves into the result register.
// Throughput: one word per cycle; the input register advances whenever the result
// register is empty or being taken. Asynchronous active-low reset resets all state but
// the input payload and restores register defaults. Depends on ibsc_pkg and ibsc_move.
module idle_bouncing_sprite_controller_unit
  import ibsc_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic        [TIME_BITS-1:0]   now_ms_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          frame_o,
  output logic                          saver_on_o,
  output logic                          repaint_desktop_o,
  output logic signed [COORD_BITS-1:0]  pos_x_o,
  output logic signed [COORD_BITS-1:0]  pos_y_o,
  output logic                          accent_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic        [TIME_BITS-1:0]   cfg_data_i
);

  // Configuration registers.
  logic [TIME_BITS-1:0]     idle_timeout_q;
  logic [INTERVAL_BITS-1:0] frame_interval_q;
  logic [DIM_BITS-1:0]      screen_w_q, screen_h_q, sprite_w_q, sprite_h_q;

  // Input register.
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_op_q;
  logic [TIME_BITS-1:0] s1_now_q;

  // Controller state.
  logic [TIME_BITS-1:0]         last_act_q, last_act_d;
  logic [TIME_BITS-1:0]         last_frame_q, last_frame_d;
  logic                         active_q, active_d;
  logic signed [COORD_BITS-1:0] spr_x_q, spr_x_d, spr_y_q, spr_y_d;
  motion_t                      mot_q, mot_d;

  // Result register; the sprite and saver fields are read straight from state.
  logic res_valid_q, res_valid_d;
  logic frame_q, frame_d;
  logic repaint_q, repaint_d;

  logic in_accept, s1_adv;
  logic [TIME_BITS-1:0]         act_eff, idle_ms, frame_ms;
  logic                         idle_ok, activating, frame_ok;
  logic signed [COORD_BITS-1:0] base_x, base_y, mv_x, mv_y;
  motion_t                      base_mot, mv_mot;

  // Handshake: the input register moves on when the result slot frees up.
  assign s1_adv      = s1_valid_q & (~res_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_accept | (s1_valid_q & ~s1_adv);
  assign res_valid_d = s1_adv | (res_valid_q & out_stall_i);
  assign cfg_ready_o = 1'b1;

  // Idle and frame timing, all differences modulo 2^32.
  assign act_eff    = (last_act_q == '0) ? s1_now_q : last_act_q;
  assign idle_ms    = s1_now_q - act_eff;
  assign frame_ms   = s1_now_q - last_frame_q;
  assign idle_ok    = idle_ms >= idle_timeout_q;
  assign activating = ~active_q & idle_ok;
  assign frame_ok   = activating ? (frame_interval_q == '0)
                                 : (frame_ms >= TIME_BITS'(frame_interval_q));

  // Activation restarts the sprite before it is moved.
  assign base_x   = activating ? COORD_BITS'(SPRITE_START_POS) : spr_x_q;
  assign base_y   = activating ? COORD_BITS'(SPRITE_START_POS) : spr_y_q;
  assign base_mot = activating ? motion_t'('0) : mot_q;

  ibsc_move #(
    .COORD_BITS(COORD_BITS)
  ) u_move (
    .x_i    (base_x),
    .y_i    (base_y),
    .mot_i  (base_mot),
    .scr_w_i(screen_w_q),
    .scr_h_i(screen_h_q),
    .spr_w_i(sprite_w_q),
    .spr_h_i(sprite_h_q),
    .x_o    (mv_x),
    .y_o    (mv_y),
    .mot_o  (mv_mot)
  );

  // Next state for the word in the input register.
  always_comb begin
    last_act_d   = last_act_q;
    last_frame_d = last_frame_q;
    active_d     = active_q;
    spr_x_d      = spr_x_q;
    spr_y_d      = spr_y_q;
    mot_d        = mot_q;
    frame_d      = 1'b0;
    repaint_d    = 1'b0;
    if (s1_op_q == OP_KICK) begin
      last_act_d = s1_now_q;
      if (active_q) begin
        active_d  = 1'b0;
        repaint_d = 1'b1;
      end
    end else begin
      last_act_d = act_eff;
      if (activating) begin
        active_d     = 1'b1;
        spr_x_d      = base_x;
        spr_y_d      = base_y;
        mot_d        = base_mot;
        last_frame_d = s1_now_q;
      end
      if ((active_q | idle_ok) & frame_ok) begin
        last_frame_d = s1_now_q;
        spr_x_d      = mv_x;
        spr_y_d      = mv_y;
        mot_d        = mv_mot;
        frame_d      = 1'b1;
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q   <= IDLE_TIMEOUT_RST;
      frame_interval_q <= FRAME_INTERVAL_RST;
      screen_w_q       <= SCREEN_WIDTH_RST;
      screen_h_q       <= SCREEN_HEIGHT_RST;
      sprite_w_q       <= SPRITE_WIDTH_RST;
      sprite_h_q       <= SPRITE_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_data_i;
        CFG_FRAME_INTERVAL: frame_interval_q <= cfg_data_i[INTERVAL_BITS-1:0];
        CFG_SCREEN_WIDTH:   screen_w_q       <= cfg_data_i[DIM_BITS-1:0];
        CFG_SCREEN_HEIGHT:  screen_h_q       <= cfg_data_i[DIM_BITS-1:0];
        CFG_SPRITE_WIDTH:   sprite_w_q       <= cfg_data_i[DIM_BITS-1:0];
        CFG_SPRITE_HEIGHT:  sprite_h_q       <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= op_i;
      s1_now_q <= now_ms_i;
    end
  end

  // State and result flags change only when a word moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_act_q   <= '0;
      last_frame_q <= '0;
      active_q     <= 1'b0;
      spr_x_q      <= COORD_BITS'(SPRITE_RESET_POS);
      spr_y_q      <= COORD_BITS'(SPRITE_RESET_POS);
      mot_q        <= '0;
      frame_q      <= 1'b0;
      repaint_q    <= 1'b0;
    end else if (s1_adv) begin
      last_act_q   <= last_act_d;
      last_frame_q <= last_frame_d;
      active_q     <= active_d;
      spr_x_q      <= spr_x_d;
      spr_y_q      <= spr_y_d;
      mot_q        <= mot_d;
      frame_q      <= frame_d;
      repaint_q    <= repaint_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign frame_o           = frame_q;
  assign saver_on_o        = active_q;
  assign repaint_desktop_o = repaint_q;
  assign pos_x_o           = spr_x_q;
  assign pos_y_o           = spr_y_q;
  assign accent_o          = mot_q.accent;

`ifndef NO_ASSERTIONS
  // A repaint only follows a kick that switched the saver off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && repaint_desktop_o) |-> !saver_on_o)
    else $error("repaint reported while saver still on");

  // A frame is only produced while the saver is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_o) |-> saver_on_o)
    else $error("frame reported while saver off");

  // The input side never stalls while the result slot is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // The sprite does not move unless a word advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(spr_x_q) && $stable(spr_y_q) && $stable(mot_q)))
    else $error("sprite state changed without an advancing word");
`endif

endmodule
